>>> src/mtsc_pkg.sv
// Package for the memory tag store and check unit.
// Holds request/response types, kind and status codes, and the microcode ROM.
// No dependencies.
package mtsc_pkg;

	localparam int GRANULE_BYTES       = 16;
	localparam int GRAN_SHIFT          = 4;
	localparam int ADDR_W              = 20;
	localparam int IDX_W               = 20;
	localparam int TAG_W               = 4;
	localparam int STEP_W              = 4;
	localparam int ADDR_GRANULES       = 2 ** (ADDR_W - GRAN_SHIFT);
	localparam int DEF_PAGE_BYTES      = 4096;
	localparam int DEF_MEMORY_GRANULES = 65536;

	localparam logic [2:0] KIND_LOAD  = 3'd0;
	localparam logic [2:0] KIND_STORE = 3'd1;
	localparam logic [2:0] KIND_CHECK = 3'd2;
	localparam logic [2:0] KIND_CLEAR = 3'd3;
	localparam logic [2:0] KIND_COPY  = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DENIED   = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;

	localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_DISP  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_RD0   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_RD1   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_RD2   = 4'd4;
	localparam logic [STEP_W-1:0] STEP_WR0   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_WR1   = 4'd6;
	localparam logic [STEP_W-1:0] STEP_CL    = 4'd7;
	localparam logic [STEP_W-1:0] STEP_CPRD  = 4'd8;
	localparam logic [STEP_W-1:0] STEP_CPWR  = 4'd9;
	localparam logic [STEP_W-1:0] STEP_FIN   = 4'd10;
	localparam logic [STEP_W-1:0] STEP_ERASE = 4'd11;
	localparam logic [STEP_W-1:0] STEP_PGSET = 4'd12;

	localparam logic [2:0] SEQ_WAIT     = 3'd0;
	localparam logic [2:0] SEQ_NEXT     = 3'd1;
	localparam logic [2:0] SEQ_JUMP     = 3'd2;
	localparam logic [2:0] SEQ_DISP     = 3'd3;
	localparam logic [2:0] SEQ_PAGE     = 3'd4;
	localparam logic [2:0] SEQ_LOOP     = 3'd5;
	localparam logic [2:0] SEQ_LOOP_END = 3'd6;
	localparam logic [2:0] SEQ_FIN      = 3'd7;

	localparam logic [2:0] ASEL_G0  = 3'd0;
	localparam logic [2:0] ASEL_G1  = 3'd1;
	localparam logic [2:0] ASEL_SRC = 3'd2;
	localparam logic [2:0] ASEL_DST = 3'd3;
	localparam logic [2:0] ASEL_CNT = 3'd4;

	localparam logic [1:0] WSEL_ZERO = 2'd0;
	localparam logic [1:0] WSEL_TAG  = 2'd1;
	localparam logic [1:0] WSEL_MEM  = 2'd2;

	typedef struct packed {
		logic [2:0]        kind;
		logic [ADDR_W-1:0] byte_address;
		logic [1:0]        granule_count;
		logic [TAG_W-1:0]  tag_value;
		logic [TAG_W-1:0]  ptr_tag;
		logic [6:0]        access_size;
		logic              start_permitted;
		logic              end_permitted;
		logic [7:0]        source_page;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [TAG_W-1:0] first_tag;
		logic [TAG_W-1:0] second_tag;
	} rsp_t;

	typedef struct packed {
		logic [2:0]        seq;
		logic [STEP_W-1:0] target;
		logic              last_mem;
		logic [2:0]        asel;
		logic              rd;
		logic              wr;
		logic [1:0]        wsel;
		logic              cap0;
		logic              cap1;
		logic              inc;
	} uword_t;

	function automatic uword_t mk_uword(input logic [2:0] seq, input logic [STEP_W-1:0] target,
			input logic last_mem, input logic [2:0] asel, input logic rd, input logic wr,
			input logic [1:0] wsel, input logic cap0, input logic cap1, input logic inc);
		uword_t w;
		w.seq      = seq;
		w.target   = target;
		w.last_mem = last_mem;
		w.asel     = asel;
		w.rd       = rd;
		w.wr       = wr;
		w.wsel     = wsel;
		w.cap0     = cap0;
		w.cap1     = cap1;
		w.inc      = inc;
		return w;
	endfunction

	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		case (step)
			STEP_IDLE:  w = mk_uword(SEQ_WAIT, STEP_IDLE, 1'b0, ASEL_G0, 1'b0, 1'b0,
					WSEL_ZERO, 1'b0, 1'b0, 1'b0);
			STEP_DISP:  w = mk_uword(SEQ_DISP, STEP_IDLE, 1'b0, ASEL_G0, 1'b0, 1'b0,
					WSEL_ZERO, 1'b0, 1'b0, 1'b0);
			STEP_PGSET: w = mk_uword(SEQ_PAGE, STEP_IDLE, 1'b0, ASEL_G0, 1'b0, 1'b0,
					WSEL_ZERO, 1'b0, 1'b0, 1'b0);
			STEP_RD0:   w = mk_uword(SEQ_NEXT, STEP_IDLE, 1'b0, ASEL_G0, 1'b1, 1'b0,
					WSEL_ZERO, 1'b0, 1'b0, 1'b0);
			STEP_RD1:   w = mk_uword(SEQ_NEXT, STEP_IDLE, 1'b0, ASEL_G1, 1'b1, 1'b0,
					WSEL_ZERO, 1'b1, 1'b0, 1'b0);
			STEP_RD2:   w = mk_uword(SEQ_JUMP, STEP_FIN, 1'b0, ASEL_G0, 1'b0, 1'b0,
					WSEL_ZERO, 1'b0, 1'b1, 1'b0);
			STEP_WR0:   w = mk_uword(SEQ_NEXT, STEP_IDLE, 1'b0, ASEL_G0, 1'b0, 1'b1,
					WSEL_TAG, 1'b0, 1'b0, 1'b0);
			STEP_WR1:   w = mk_uword(SEQ_JUMP, STEP_FIN, 1'b0, ASEL_G1, 1'b0, 1'b1,
					WSEL_TAG, 1'b0, 1'b0, 1'b0);
			STEP_CL:    w = mk_uword(SEQ_LOOP, STEP_CL, 1'b0, ASEL_DST, 1'b0, 1'b1,
					WSEL_ZERO, 1'b0, 1'b0, 1'b1);
			STEP_CPRD:  w = mk_uword(SEQ_NEXT, STEP_IDLE, 1'b0, ASEL_SRC, 1'b1, 1'b0,
					WSEL_ZERO, 1'b0, 1'b0, 1'b0);
			STEP_CPWR:  w = mk_uword(SEQ_LOOP, STEP_CPRD, 1'b0, ASEL_DST, 1'b0, 1'b1,
					WSEL_MEM, 1'b0, 1'b0, 1'b1);
			STEP_FIN:   w = mk_uword(SEQ_FIN, STEP_IDLE, 1'b0, ASEL_G0, 1'b0, 1'b0,
					WSEL_ZERO, 1'b0, 1'b0, 1'b0);
			STEP_ERASE: w = mk_uword(SEQ_LOOP_END, STEP_ERASE, 1'b1, ASEL_CNT, 1'b0, 1'b1,
					WSEL_ZERO, 1'b0, 1'b0, 1'b1);
			default:    w = mk_uword(SEQ_JUMP, STEP_IDLE, 1'b0, ASEL_G0, 1'b0, 1'b0,
					WSEL_ZERO, 1'b0, 1'b0, 1'b0);
		endcase
		return w;
	endfunction

endpackage

>>> src/memory_tag_store_and_check_unit.sv
// Top level of the memory tag store and check unit: tag memory, datapath
// and microcoded sequencer. Depends on mtsc_pkg.
//
// channel   direction  handshake               payload
// request   in         start, busy             req (req_t)
// result    out        done (one-cycle strobe) rsp (rsp_t)
// config    in         cfg_valid, cfg_ready    cfg_data (tag check enable)
//
// Requests settled without memory skip the tag memory; store, load, tag-checked
// access, page clear and page copy take their steps in turn on the single-port
// tag memory.
// After reset the unit sweeps MEM_DEPTH entries to zero, one per cycle, with
// busy high; config writes are taken throughout (cfg_ready is always high).
// The result strobe cannot be stalled; a new request may start in the cycle
// the strobe is high.
module memory_tag_store_and_check_unit #(
	parameter int PAGE_BYTES      = mtsc_pkg::DEF_PAGE_BYTES,
	parameter int MEMORY_GRANULES = mtsc_pkg::DEF_MEMORY_GRANULES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mtsc_pkg::req_t req,
	output logic          done,
	output mtsc_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);
	import mtsc_pkg::*;

	localparam int PAGE_GRANULES = PAGE_BYTES / GRANULE_BYTES;
	localparam int MEM_DEPTH     = (MEMORY_GRANULES < ADDR_GRANULES + 1) ?
			MEMORY_GRANULES : ADDR_GRANULES + 1;
	localparam int MEM_AW        = $clog2(MEM_DEPTH);
	localparam int PG_AW         = $clog2(PAGE_GRANULES);
	localparam int CNT_W         = (MEM_AW > PG_AW) ? MEM_AW : PG_AW;
	localparam int DIV_SHIFT     = ADDR_W + $clog2(PAGE_BYTES);
	localparam logic [63:0] DIV_MUL = ((64'd1 << DIV_SHIFT) + 64'(PAGE_BYTES) - 64'd1) /
			64'(PAGE_BYTES);
	localparam int MUL_W         = $clog2(DIV_MUL + 64'd1);
	localparam int PROD_W        = ADDR_W + MUL_W;
	localparam int PQ_W          = $clog2((2 ** ADDR_W) / PAGE_BYTES + 1);
	localparam int PAGE_LIM      = (MEMORY_GRANULES + PAGE_GRANULES - 1) / PAGE_GRANULES;
	localparam bit PAGE_LIM_HIT  = PAGE_LIM < 2 ** PQ_W;
	localparam int LAST_W        = ADDR_W + 1;
	localparam int LIMIT_BYTES   = MEMORY_GRANULES * GRANULE_BYTES;
	localparam bit LIMIT_HIT     = LIMIT_BYTES < 2 ** LAST_W;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_nxt;
	req_t              req_q;
	logic [PQ_W-1:0]   pgq_q;
	logic              enable_q;
	logic [1:0]        st_q;
	logic              cmp_q;
	logic              pair_q;
	logic              ldout_q;
	logic [IDX_W-1:0]  g1_q;
	logic [IDX_W-1:0]  dst_q;
	logic [IDX_W-1:0]  src_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TAG_W-1:0]  tag0_q;
	logic [TAG_W-1:0]  tag1_q;
	logic [TAG_W-1:0]  mem [MEM_DEPTH];
	logic [TAG_W-1:0]  mem_q;
	logic              inb_q;
	logic              done_q;
	rsp_t              rsp_q;

	uword_t            uw;
	logic [PROD_W-1:0] prod;
	logic [IDX_W-1:0]  g0;
	logic [IDX_W-1:0]  lg;
	logic [IDX_W:0]    g_last;
	logic [LAST_W-1:0] last_byte;
	logic              two;
	logic              d_final;
	logic              d_cmp;
	logic              d_pair;
	logic              d_ldout;
	logic [1:0]        d_st;
	logic [IDX_W-1:0]  d_g1;
	logic [STEP_W-1:0] disp_nxt;
	logic [IDX_W-1:0]  maddr;
	logic              in_range;
	logic              gate2;
	logic              we;
	logic [TAG_W-1:0]  wdata;
	logic [TAG_W-1:0]  rdata;
	logic              last;
	logic              mismatch;

	assign uw        = ucode(step_q);
	assign busy      = step_q != STEP_IDLE;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	assign prod = PROD_W'(req.byte_address) * PROD_W'(DIV_MUL);

	assign g0        = IDX_W'(req_q.byte_address >> GRAN_SHIFT);
	assign two       = req_q.granule_count == 2'd2;
	assign g_last    = {1'b0, g0} + (IDX_W + 1)'(two);
	assign last_byte = LAST_W'(req_q.byte_address) + LAST_W'(req_q.access_size) - LAST_W'(1);
	assign lg        = IDX_W'(last_byte >> GRAN_SHIFT);

	always_comb begin
		d_st    = ST_OK;
		d_final = 1'b1;
		d_cmp   = 1'b0;
		d_pair  = 1'b0;
		d_ldout = 1'b0;
		d_g1    = g0 + IDX_W'(1);
		case (req_q.kind)
			KIND_LOAD, KIND_STORE: begin
				if (!(req_q.granule_count inside {2'd1, 2'd2}) ||
						!(req_q.start_permitted && req_q.end_permitted) ||
						g_last >= (IDX_W + 1)'(MEMORY_GRANULES)) begin
					d_st = ST_DENIED;
				end else begin
					d_final = 1'b0;
					d_pair  = two;
					d_ldout = req_q.kind == KIND_LOAD;
				end
			end
			KIND_CHECK: begin
				if (req_q.access_size == 7'd0) begin
					d_st = ST_OK;
				end else if (LIMIT_HIT && last_byte >= LAST_W'(LIMIT_BYTES)) begin
					d_st = ST_DENIED;
				end else if ((lg - g0) > IDX_W'(1)) begin
					d_st = ST_DENIED;
				end else if (!req_q.start_permitted) begin
					d_st = ST_OK;
				end else if (!req_q.end_permitted) begin
					d_st = ST_DENIED;
				end else if (enable_q) begin
					d_final = 1'b0;
					d_cmp   = 1'b1;
					d_pair  = 1'b1;
					d_g1    = lg;
				end
			end
			KIND_CLEAR, KIND_COPY: begin
				if (PAGE_LIM_HIT && pgq_q >= PQ_W'(PAGE_LIM)) begin
					d_st = ST_DENIED;
				end else begin
					d_final = 1'b0;
				end
			end
			default: begin
				d_st = ST_DENIED;
			end
		endcase
	end

	always_comb begin
		if (d_final) begin
			disp_nxt = STEP_FIN;
		end else begin
			case (req_q.kind)
				KIND_LOAD, KIND_CHECK: disp_nxt = STEP_RD0;
				KIND_STORE:            disp_nxt = STEP_WR0;
				default:               disp_nxt = STEP_PGSET;
			endcase
		end
	end

	always_comb begin
		case (uw.asel)
			ASEL_G1:  maddr = g1_q;
			ASEL_SRC: maddr = src_q + IDX_W'(cnt_q);
			ASEL_DST: maddr = dst_q + IDX_W'(cnt_q);
			ASEL_CNT: maddr = IDX_W'(cnt_q);
			default:  maddr = g0;
		endcase
	end

	assign in_range = maddr < IDX_W'(MEM_DEPTH);
	assign gate2    = (uw.asel == ASEL_G1) ? pair_q : 1'b1;
	assign we       = uw.wr && gate2 && in_range;
	assign rdata    = inb_q ? mem_q : '0;

	always_comb begin
		case (uw.wsel)
			WSEL_TAG: wdata = req_q.tag_value;
			WSEL_MEM: wdata = rdata;
			default:  wdata = '0;
		endcase
	end

	assign last = uw.last_mem ? (cnt_q == CNT_W'(MEM_DEPTH - 1)) :
			(cnt_q == CNT_W'(PAGE_GRANULES - 1));

	assign mismatch = cmp_q && (tag0_q != req_q.ptr_tag || tag1_q != req_q.ptr_tag);

	always_comb begin
		case (uw.seq)
			SEQ_WAIT:     step_nxt = start ? STEP_DISP : STEP_IDLE;
			SEQ_NEXT:     step_nxt = step_q + STEP_W'(1);
			SEQ_JUMP:     step_nxt = uw.target;
			SEQ_DISP:     step_nxt = disp_nxt;
			SEQ_PAGE:     step_nxt = (req_q.kind == KIND_CLEAR) ? STEP_CL : STEP_CPRD;
			SEQ_LOOP:     step_nxt = last ? STEP_FIN : uw.target;
			SEQ_LOOP_END: step_nxt = last ? STEP_IDLE : uw.target;
			default:      step_nxt = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_ERASE;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			enable_q <= 1'b0;
		end else begin
			step_q <= step_nxt;
			done_q <= uw.seq == SEQ_FIN;
			if (cfg_valid) begin
				enable_q <= cfg_data;
			end
			if (uw.seq == SEQ_DISP) begin
				cnt_q <= '0;
			end else if (uw.inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (uw.seq == SEQ_WAIT && start) begin
			req_q <= req;
			pgq_q <= PQ_W'(prod >> DIV_SHIFT);
		end
		if (uw.seq == SEQ_DISP) begin
			st_q    <= d_st;
			cmp_q   <= d_cmp;
			pair_q  <= d_pair;
			ldout_q <= d_ldout;
			g1_q    <= d_g1;
			tag0_q  <= '0;
			tag1_q  <= '0;
		end
		if (uw.seq == SEQ_PAGE) begin
			dst_q <= IDX_W'(IDX_W'(pgq_q) * IDX_W'(PAGE_GRANULES));
			src_q <= IDX_W'(IDX_W'(req_q.source_page) * IDX_W'(PAGE_GRANULES));
		end
		if (uw.cap0) begin
			tag0_q <= rdata;
		end
		if (uw.cap1 && pair_q) begin
			tag1_q <= rdata;
		end
		if (uw.seq == SEQ_FIN) begin
			rsp_q.status     <= mismatch ? ST_MISMATCH : st_q;
			rsp_q.first_tag  <= ldout_q ? tag0_q : '0;
			rsp_q.second_tag <= ldout_q ? tag1_q : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[maddr[MEM_AW-1:0]] <= wdata;
		end
		if (uw.rd) begin
			mem_q <= mem[maddr[MEM_AW-1:0]];
			inb_q <= in_range;
		end
	end

endmodule

>>> src/mtsc_chk.sv
// Port-level checker for the memory tag store and check unit, with its bind.
// Depends on mtsc_pkg and memory_tag_store_and_check_unit.
module mtsc_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input mtsc_pkg::rsp_t rsp
);
	import mtsc_pkg::*;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
			done |-> $past(busy))
		else $error("result strobe without a request in flight");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
			done |=> !done)
		else $error("result strobe held for two cycles");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
			start && !busy |=> busy)
		else $error("request transfer did not raise busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
			done |-> rsp.status == ST_OK || rsp.status == ST_DENIED ||
				rsp.status == ST_MISMATCH)
		else $error("undefined status code");

	a_fail_no_tags: assert property (@(posedge clk) disable iff (!arst_n)
			done && rsp.status != ST_OK |-> rsp.first_tag == '0 && rsp.second_tag == '0)
		else $error("tags returned with a failing status");

endmodule

bind memory_tag_store_and_check_unit mtsc_chk u_mtsc_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

>>> tb/sv/testbench.sv
// Testbench for memory_tag_store_and_check_unit: directed and random requests
// with config writes between phases, each result checked against a private tag store.
// Depends on mtsc_pkg and the unit's RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mtsc_pkg::*;

	localparam int PAGE_LEN = DEF_PAGE_BYTES;
	localparam int TAG_GRANULES = DEF_MEMORY_GRANULES;
	localparam int PAGE_GRANS = PAGE_LEN / GRANULE_BYTES;
	localparam logic [2:0] KIND_SPARE_LO = 3'd5;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	localparam int MAX_GAP = 17;
	localparam int STALL_LIMIT = 4 * TAG_GRANULES;
	localparam int DRAIN_CYCLES = 2 * PAGE_GRANS + 8;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;
	req_t req;
	rsp_t rsp;

	logic [TAG_W-1:0] tag_copy [TAG_GRANULES];
	logic check_on;
	rsp_t outcome_queue [$];
	int error_count;
	int stall_cycles;
	int burst_left;
	int hot_pages [4] = '{0, 1, 128, 255};

	memory_tag_store_and_check_unit #(
		.PAGE_BYTES(PAGE_LEN),
		.MEMORY_GRANULES(TAG_GRANULES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rsp_t tag_unit_outcome(req_t r);
		rsp_t o;
		int first_g;
		int last_b;
		int last_g;
		int dst;
		int src;
		int n;
		int i;
		o = '0;
		o.status = ST_OK;
		first_g = int'(r.byte_address) / GRANULE_BYTES;
		n = int'(r.granule_count);
		case (r.kind)
			KIND_LOAD, KIND_STORE: begin
				if (n < 1 || n > 2 || !r.start_permitted || !r.end_permitted
						|| first_g + n - 1 >= TAG_GRANULES)
					o.status = ST_DENIED;
				else if (r.kind == KIND_STORE) begin
					for (i = 0; i < n; i++)
						tag_copy[first_g + i] = r.tag_value;
				end else begin
					o.first_tag = tag_copy[first_g];
					if (n == 2)
						o.second_tag = tag_copy[first_g + 1];
				end
			end
			KIND_CHECK: begin
				last_b = int'(r.byte_address) + int'(r.access_size) - 1;
				last_g = last_b / GRANULE_BYTES;
				if (r.access_size == 0)
					o.status = ST_OK;
				else if (last_b >= TAG_GRANULES * GRANULE_BYTES)
					o.status = ST_DENIED;
				else if (last_g - first_g + 1 > 2)
					o.status = ST_DENIED;
				else if (!r.start_permitted)
					o.status = ST_OK;
				else if (!r.end_permitted)
					o.status = ST_DENIED;
				else if (!check_on)
					o.status = ST_OK;
				else if (tag_copy[first_g] != r.ptr_tag
						|| tag_copy[last_g] != r.ptr_tag)
					o.status = ST_MISMATCH;
			end
			KIND_CLEAR, KIND_COPY: begin
				dst = int'(r.byte_address) / PAGE_LEN * PAGE_GRANS;
				src = int'(r.source_page) * PAGE_GRANS;
				if (dst >= TAG_GRANULES)
					o.status = ST_DENIED;
				else begin
					for (i = 0; i < PAGE_GRANS; i++) begin
						if (dst + i < TAG_GRANULES)
							tag_copy[dst + i] = (r.kind == KIND_COPY && src + i < TAG_GRANULES)
									? tag_copy[src + i] : '0;
					end
				end
			end
			default: o.status = ST_DENIED;
		endcase
		return o;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (done) begin
			if (outcome_queue.size() == 0) begin
				$error("result with no request outstanding: status %0d", rsp.status);
				error_count++;
			end else begin
				want = outcome_queue.pop_front();
				if (rsp.status != want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					error_count++;
				end
				if (rsp.first_tag != want.first_tag) begin
					$error("first_tag: expected %0d, actual %0d", want.first_tag, rsp.first_tag);
					error_count++;
				end
				if (rsp.second_tag != want.second_tag) begin
					$error("second_tag: expected %0d, actual %0d", want.second_tag,
							rsp.second_tag);
					error_count++;
				end
			end
		end
		if (arst_n && start && !busy)
			outcome_queue.push_back(tag_unit_outcome(req));
		if (arst_n && cfg_valid && cfg_ready)
			check_on = cfg_data;
		if (!arst_n || done || (start && !busy) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_request(req_t item);
		int gap;
		gap = (burst_left > 0) ? 0 : $urandom_range(0, MAX_GAP);
		if (burst_left > 0)
			burst_left--;
		else if ($urandom_range(0, 19) == 0)
			burst_left = $urandom_range(10, 40);
		@(negedge clk);
		if (gap != 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req = item;
		start = 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (outcome_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_check_enable(logic value);
		settle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic req_t make_req(logic [2:0] kind, logic [ADDR_W-1:0] addr,
			logic [1:0] count, logic [TAG_W-1:0] tag, logic [TAG_W-1:0] ltag,
			logic [6:0] size, logic sp, logic ep, logic [7:0] page);
		req_t r;
		r.kind = kind;
		r.byte_address = addr;
		r.granule_count = count;
		r.tag_value = tag;
		r.ptr_tag = ltag;
		r.access_size = size;
		r.start_permitted = sp;
		r.end_permitted = ep;
		r.source_page = page;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		logic [63:0] noise;
		int pick;
		int granule;
		int sel;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			noise = {$urandom, $urandom};
			r = noise[$bits(req_t)-1:0];
			return r;
		end
		granule = hot_pages[$urandom_range(0, 3)] * PAGE_GRANS;
		granule += $urandom_range(0, 1) ? $urandom_range(0, 5)
				: PAGE_GRANS - 1 - $urandom_range(0, 2);
		if ($urandom_range(0, 9) == 0)
			granule = $urandom_range(0, TAG_GRANULES - 1);
		r = '0;
		r.byte_address = ADDR_W'(granule * GRANULE_BYTES + $urandom_range(0, 15));
		r.granule_count = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
				: 2'($urandom_range(1, 2));
		r.tag_value = TAG_W'($urandom);
		r.start_permitted = $urandom_range(0, 7) != 0;
		r.end_permitted = $urandom_range(0, 7) != 0;
		r.ptr_tag = ($urandom_range(0, 2) != 0) ? tag_copy[granule] : TAG_W'($urandom);
		sel = $urandom_range(0, 19);
		if (sel == 0)
			r.access_size = '0;
		else if (sel < 3)
			r.access_size = 7'($urandom_range(33, 127));
		else
			r.access_size = 7'($urandom_range(1, 32));
		r.source_page = $urandom_range(0, 1) ? 8'(hot_pages[$urandom_range(0, 3)])
				: 8'($urandom);
		if (pick < 26)
			r.kind = KIND_LOAD;
		else if (pick < 48)
			r.kind = KIND_STORE;
		else if (pick < 86)
			r.kind = KIND_CHECK;
		else if (pick < 89)
			r.kind = KIND_CLEAR;
		else if (pick < 93)
			r.kind = KIND_COPY;
		else
			r.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
		return r;
	endfunction

	task automatic run_random(int count);
		repeat (count) send_request(random_request());
	endtask

	task automatic test_directed_cases();
		set_check_enable(1'b1);
		send_request(make_req(KIND_LOAD, 20'h00000, 2'd1, 4'h0, 4'h0, 7'd0, 1'b1, 1'b1, 8'h00));
		send_request(make_req(KIND_STORE, 20'h00010, 2'd2, 4'hF, 4'h0, 7'd0, 1'b1, 1'b1, 8'h00));
		send_request(make_req(KIND_LOAD, 20'h00010, 2'd2, 4'h0, 4'h0, 7'd0, 1'b1, 1'b1, 8'h00));
		send_request(make_req(KIND_STORE, 20'hFFFF0, 2'd1, 4'hA, 4'h0, 7'd0, 1'b1, 1'b1, 8'h00));
		send_request(make_req(KIND_LOAD, 20'hFFFF0, 2'd2, 4'h0, 4'h0, 7'd0, 1'b1, 1'b1, 8'h00));
		send_request(make_req(KIND_LOAD, 20'hFFFFF, 2'd1, 4'h0, 4'h0, 7'd0, 1'b1, 1'b1, 8'h00));
		send_request(make_req(KIND_STORE, 20'h00040, 2'd0, 4'h5, 4'h0, 7'd0, 1'b1, 1'b1, 8'h00));
		send_request(make_req(KIND_STORE, 20'h00040, 2'd3, 4'h5, 4'h0, 7'd0, 1'b1, 1'b1, 8'h00));
		send_request(make_req(KIND_LOAD, 20'h00010, 2'd1, 4'h0, 4'h0, 7'd0, 1'b0, 1'b1, 8'h00));
		send_request(make_req(KIND_STORE, 20'h00010, 2'd1, 4'h3, 4'h0, 7'd0, 1'b1, 1'b0, 8'h00));
		send_request(make_req(KIND_CHECK, 20'hFFFFF, 2'd0, 4'h0, 4'h7, 7'd0, 1'b1, 1'b1, 8'h00));
		send_request(make_req(KIND_CHECK, 20'h00010, 2'd0, 4'h0, 4'hF, 7'd16, 1'b1, 1'b1,
				8'h00));
		send_request(make_req(KIND_CHECK, 20'h00018, 2'd0, 4'h0, 4'hF, 7'd16, 1'b1, 1'b1,
				8'h00));
		send_request(make_req(KIND_CHECK, 20'h00018, 2'd0, 4'h0, 4'h3, 7'd16, 1'b1, 1'b1,
				8'h00));
		send_request(make_req(KIND_CHECK, 20'h00010, 2'd0, 4'h0, 4'hF, 7'd127, 1'b1, 1'b1,
				8'h00));
		send_request(make_req(KIND_CHECK, 20'hFFFFF, 2'd0, 4'h0, 4'hA, 7'd2, 1'b1, 1'b1, 8'h00));
		send_request(make_req(KIND_CHECK, 20'hFFFFF, 2'd0, 4'h0, 4'hA, 7'd1, 1'b1, 1'b1, 8'h00));
		send_request(make_req(KIND_CHECK, 20'h00010, 2'd0, 4'h0, 4'h1, 7'd8, 1'b0, 1'b0, 8'h00));
		send_request(make_req(KIND_CHECK, 20'h00010, 2'd0, 4'h0, 4'hF, 7'd8, 1'b1, 1'b0, 8'h00));
		send_request(make_req(KIND_COPY, 20'h00ABC, 2'd0, 4'h0, 4'h0, 7'd0, 1'b1, 1'b1, 8'hFF));
		send_request(make_req(KIND_LOAD, 20'h00FF0, 2'd1, 4'h0, 4'h0, 7'd0, 1'b1, 1'b1, 8'h00));
		send_request(make_req(KIND_CLEAR, 20'h00ABC, 2'd0, 4'h0, 4'h0, 7'd0, 1'b0, 1'b0, 8'h00));
		send_request(make_req(KIND_LOAD, 20'h00FF0, 2'd2, 4'h0, 4'h0, 7'd0, 1'b1, 1'b1, 8'h00));
		send_request(make_req(KIND_SPARE_LO, 20'h00010, 2'd1, 4'h0, 4'h0, 7'd0, 1'b1, 1'b1,
				8'h00));
		send_request(make_req(KIND_SPARE_HI, 20'hFFFFF, 2'd2, 4'hF, 4'hF, 7'd127, 1'b1, 1'b1,
				8'hFF));
	endtask

	task automatic test_random_check_enabled();
		set_check_enable(1'b1);
		run_random(700);
	endtask

	task automatic test_random_check_disabled();
		set_check_enable(1'b0);
		run_random(300);
	endtask

	task automatic test_enable_toggling();
		int round;
		for (round = 0; round < 6; round++) begin
			set_check_enable(round[0]);
			run_random(100);
		end
	endtask

	initial begin
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		arst_n = 1'b0;
		check_on = 1'b0;
		error_count = 0;
		stall_cycles = 0;
		burst_left = 0;
		foreach (tag_copy[i])
			tag_copy[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_cases();
		test_random_check_enabled();
		test_random_check_disabled();
		test_enable_toggling();
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
